@@ hdl/palm_pkg.sv @@
// palm_pkg: shared types, codes and helpers for the palette blend / nearest index block
// no dependencies
`default_nettype none
package palm_pkg;

   localparam int PALETTE_ENTRIES = 256;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_BLEND = 2'd1;
   localparam logic [1:0] CMD_FIND  = 2'd2;

   localparam logic [2:0] MODE_MULTIPLY = 3'd0;
   localparam logic [2:0] MODE_SCREEN   = 3'd1;
   localparam logic [2:0] MODE_OVERLAY  = 3'd2;
   localparam logic [2:0] MODE_HARD     = 3'd3;
   localparam logic [2:0] MODE_DODGE    = 3'd4;
   localparam logic [2:0] MODE_HALF     = 3'd5;

   localparam int DIV_STEPS = 8;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] fore_index;
      logic [7:0] back_index;
   } op_type;

   // exact x/255 for x up to 65279; the 8-bit result wraps above that
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage
`default_nettype wire

@@ hdl/palm_fifo.sv @@
// palm_fifo: two-entry queue of decoded operations between front and back
// depends on palm_pkg
`default_nettype none
module palm_fifo (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire palm_pkg::op_type push_op,
   output logic                 full,
   input  wire logic            pop,
   output logic                 not_empty,
   output palm_pkg::op_type     head_op
);
   palm_pkg::op_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_op   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   ap_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue push while full");
   ap_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue pop while empty");
   ap_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

@@ hdl/palm_back.sv @@
// palm_back: palette memory, blend datapath, dodge divider and nearest search
// depends on palm_pkg
`default_nettype none
module palm_back #(
   parameter int PALETTE_ENTRIES = palm_pkg::PALETTE_ENTRIES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_valid,
   input  wire palm_pkg::op_type op,
   output logic                 op_pop,
   input  wire logic [2:0]       blend_mode,
   output logic                 rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]           rsp_nearest_index
);
   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [8:0] ENTRIES = 9'(PALETTE_ENTRIES);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_FORE  = 9'b000000010,
      ST_BACK  = 9'b000000100,
      ST_MIX   = 9'b000001000,
      ST_DIV   = 9'b000010000,
      ST_FIN   = 9'b000100000,
      ST_SRCH  = 9'b001000000,
      ST_DRAIN = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] mem [PALETTE_ENTRIES];
   logic [23:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic        mem_we;

   logic [AW:0] cnt_ff, cnt_in;
   logic [3:0]  step_ff, step_in;
   logic        toggle_ff, toggle_in;

   logic [7:0] fg_ff [3];
   logic [7:0] bk_ff [3];
   logic       back_ok_ff;
   logic [7:0] back_idx_ff;
   logic [15:0] prod_ff [3];
   logic [7:0] add_ff [3];
   logic       inv_ff [3];
   logic [7:0] half_ff [3];
   logic       sat_ff [3];
   logic [8:0] rem_ff [3];
   logic [8:0] dv_ff [3];
   logic [7:0] quo_ff [3];
   logic [7:0] tgt_ff [3];

   logic       v1_ff, v1_in;
   logic [7:0] idx1_ff;
   logic       v2_ff;
   logic [7:0] idx2_ff;
   logic [9:0] dist_ff;
   logic [9:0] best_ff;
   logic [7:0] best_idx_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_idx_ff;
   logic       rsp_load;

   logic [7:0] mem_ch [3];
   logic [9:0] dist_in;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;

   always_comb begin
      mem_ch[0] = rd_data_ff[23:16];
      mem_ch[1] = rd_data_ff[15:8];
      mem_ch[2] = rd_data_ff[7:0];
      dist_in = 10'(mem_ch[0] > tgt_ff[0] ? mem_ch[0] - tgt_ff[0] : tgt_ff[0] - mem_ch[0])
              + 10'(mem_ch[1] > tgt_ff[1] ? mem_ch[1] - tgt_ff[1] : tgt_ff[1] - mem_ch[1])
              + 10'(mem_ch[2] > tgt_ff[2] ? mem_ch[2] - tgt_ff[2] : tgt_ff[2] - mem_ch[2]);
   end

   // control
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      toggle_in = toggle_ff;
      op_pop    = 1'b0;
      mem_we    = 1'b0;
      rd_addr   = cnt_ff[AW-1:0];
      v1_in     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = op.fore_index[AW-1:0];
            if (op_valid) begin
               op_pop = 1'b1;
               case (op.cmd)
                  palm_pkg::CMD_WRITE: mem_we = ({1'b0, op.entry_index} < ENTRIES);
                  palm_pkg::CMD_BLEND: state_in = ST_FORE;
                  default: begin
                     cnt_in   = '0;
                     state_in = ST_SRCH;
                  end
               endcase
            end
         end
         ST_FORE: begin
            rd_addr  = back_idx_ff[AW-1:0];
            state_in = ST_BACK;
         end
         ST_BACK: state_in = ST_MIX;
         ST_MIX: begin
            step_in = '0;
            if (blend_mode == palm_pkg::MODE_HALF) begin
               toggle_in = ~toggle_ff;
            end
            state_in = (blend_mode == palm_pkg::MODE_DODGE) ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(palm_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cnt_in   = '0;
            state_in = ST_SRCH;
         end
         ST_SRCH: begin
            v1_in  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(PALETTE_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         toggle_ff    <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         toggle_ff    <= toggle_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[op.entry_index[AW-1:0]] <= {op.red, op.green, op.blue};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // blend datapath
   always_ff @(posedge clock) begin
      logic [7:0] a, m, f, b, x, ad;
      logic       tb, iv;
      logic [9:0] r2;
      if (state_ff == ST_IDLE && op_valid) begin
         back_ok_ff  <= ({1'b0, op.back_index} < ENTRIES);
         back_idx_ff <= op.back_index;
         if (op.cmd == palm_pkg::CMD_BLEND) begin
            fg_ff[0] <= ({1'b0, op.fore_index} < ENTRIES) ? 8'hff : 8'h00;
         end else begin
            tgt_ff[0] <= op.red;
            tgt_ff[1] <= op.green;
            tgt_ff[2] <= op.blue;
         end
      end
      for (int c = 0; c < 3; c++) begin
         f  = fg_ff[c];
         b  = bk_ff[c];
         a  = f;
         m  = b;
         x  = '0;
         ad = '0;
         iv = 1'b0;
         tb = (c == 1) ? toggle_ff : ~toggle_ff;
         r2 = {rem_ff[c], 1'b0};
         if (state_ff == ST_FORE) begin
            // fg_ff[0] holds the in-range flag until the fore data lands
            fg_ff[c] <= fg_ff[0][0] ? mem_ch[c] : 8'h00;
         end
         if (state_ff == ST_BACK) begin
            bk_ff[c] <= back_ok_ff ? mem_ch[c] : 8'h00;
         end
         if (state_ff == ST_MIX) begin
            case (blend_mode)
               palm_pkg::MODE_SCREEN: begin
                  m  = ~b;
                  ad = b;
               end
               palm_pkg::MODE_OVERLAY: begin
                  x = {b[6:0], 1'b0};
                  if (!b[7]) begin
                     a = x;
                     m = f;
                  end else begin
                     a  = ~x;
                     m  = ~f;
                     iv = 1'b1;
                  end
               end
               palm_pkg::MODE_HARD: begin
                  x = {f[6:0], 1'b0};
                  if (!f[7]) begin
                     a = x;
                     m = b;
                  end else begin
                     a  = ~x;
                     m  = ~b;
                     iv = 1'b1;
                  end
               end
               default: begin
                  a = f;
                  m = b;
               end
            endcase
            add_ff[c]  <= ad;
            inv_ff[c]  <= iv;
            prod_ff[c] <= 16'(a) * 16'(m);
            half_ff[c] <= 8'((9'(f) + 9'(b) + 9'(tb)) >> 1);
            sat_ff[c]  <= (9'(f) + 9'(b)) >= 9'd256;
            rem_ff[c]  <= {1'b0, b};
            dv_ff[c]   <= 9'd256 - 9'(f);
            quo_ff[c]  <= '0;
         end
         if (state_ff == ST_DIV) begin
            // restoring division, one quotient bit per cycle
            if (r2 >= 10'(dv_ff[c])) begin
               rem_ff[c] <= 9'(r2 - 10'(dv_ff[c]));
               quo_ff[c] <= {quo_ff[c][6:0], 1'b1};
            end else begin
               rem_ff[c] <= r2[8:0];
               quo_ff[c] <= {quo_ff[c][6:0], 1'b0};
            end
         end
         if (state_ff == ST_FIN) begin
            if (blend_mode == palm_pkg::MODE_HALF) begin
               tgt_ff[c] <= half_ff[c];
            end else if (blend_mode == palm_pkg::MODE_DODGE) begin
               tgt_ff[c] <= sat_ff[c] ? 8'hff : quo_ff[c];
            end else begin
               tgt_ff[c] <= (palm_pkg::div255(prod_ff[c]) + add_ff[c]) ^ {8{inv_ff[c]}};
            end
         end
      end
   end

   // search pipeline: read, distance, compare
   always_ff @(posedge clock) begin
      idx1_ff <= 8'(cnt_ff);
      idx2_ff <= idx1_ff;
      dist_ff <= dist_in;
      if (state_ff == ST_IDLE || state_ff == ST_FIN) begin
         best_ff     <= '1;
         best_idx_ff <= '0;
      end else if (v2_ff && dist_ff < best_ff) begin
         best_ff     <= dist_ff;
         best_idx_ff <= idx2_ff;
      end
      if (rsp_load) begin
         rsp_idx_ff <= best_idx_ff;
      end
   end

   ap_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(PALETTE_ENTRIES)) else $error("search counter overran");
   ap_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_IDLE) else $error("palette write outside idle");
   ap_dist_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> dist_ff <= 10'd765) else $error("distance out of range");
   ap_done_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !v1_ff && !v2_ff) else $error("result before search drained");
endmodule
`default_nettype wire

@@ hdl/palette_blend_nearest_index.sv @@
// palette_blend_nearest_index: top level, csr register, command decode and queue
// depends on palm_pkg, palm_fifo, palm_back
//
// Usage:
//  req_ channel carries one command per transfer: write a palette entry, blend
//  two entries and search, or search for a given rgb. csr_ channel sets the blend
//  mode and is always ready; write it only while the block is idle.
//  rsp_ channel returns one nearest_index per blend or find command, in order.
//  The single memory read port, one entry per cycle, sets the search time of a
//  find or a blend; a blend first reads both entries, and dodge adds the divider.
//  Commands queue (two deep) while the back end works, so req_ready stays high
//  until the queue fills. A finished result waits in an output register while
//  the next command proceeds; a stalled receiver holds the back end only when
//  the next result is ready. Reset clears the queue, the rounding toggle and
//  the blend mode; palette contents are undefined until written.
`default_nettype none
module palette_blend_nearest_index #(
   parameter int PALETTE_ENTRIES = palm_pkg::PALETTE_ENTRIES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_entry_index,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_fore_index,
   input  wire logic [7:0] req_back_index,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_nearest_index,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_blend_mode
);
   logic             mode_valid_unused;
   logic [2:0]       mode_ff, mode_in;
   logic             q_full, q_push, q_pop, q_valid;
   palm_pkg::op_type q_in, q_head;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign mode_valid_unused = 1'b0;

   always_comb begin
      mode_in = (csr_valid && !mode_valid_unused) ? csr_blend_mode : mode_ff;
      q_in.cmd         = req_cmd;
      q_in.entry_index = req_entry_index;
      q_in.red         = req_red;
      q_in.green       = req_green;
      q_in.blue        = req_blue;
      q_in.fore_index  = req_fore_index;
      q_in.back_index  = req_back_index;
      // the unused command is dropped here
      q_push = req_valid && !q_full &&
               (req_cmd == palm_pkg::CMD_WRITE || req_cmd == palm_pkg::CMD_BLEND ||
                req_cmd == palm_pkg::CMD_FIND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= palm_pkg::MODE_MULTIPLY;
      end else begin
         mode_ff <= mode_in;
      end
   end

   palm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_op   (q_head)
   );

   palm_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (q_valid),
      .op                (q_head),
      .op_pop            (q_pop),
      .blend_mode        (mode_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_index (rsp_nearest_index)
   );
endmodule
`default_nettype wire

@@ bench/tb_palette_blend_nearest_index.sv @@
// tb_palette_blend_nearest_index: self-checking bench for the palette blend / nearest index block
// depends on palm_pkg and palette_blend_nearest_index; predicts every rsp_ transfer
// from a local copy of the palette, the rounding toggle and the blend mode
`timescale 1ns / 1ps
module tb_palette_blend_nearest_index;

   localparam logic [1:0] CMD_NONE   = 2'd3;
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;
   localparam int MAX_CYCLES = 3000000;
   localparam int RANDOM_ITEMS = 560;

   typedef struct {
      logic [2:0] mode;
      logic [1:0] cmd;
      logic [7:0] ei, r, g, b, fi, bi;
      bit         known;
      logic [7:0] want;
   } row_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_cmd = '0;
   logic [7:0] req_entry_index = '0, req_red = '0, req_green = '0, req_blue = '0;
   logic [7:0] req_fore_index = '0, req_back_index = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_nearest_index;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [2:0] csr_blend_mode = '0;

   // local copy of the block state
   logic [23:0] shade [palm_pkg::PALETTE_ENTRIES];
   bit          toggle_bit;
   logic [2:0]  cur_mode;
   logic [7:0]  nearest_q [$];
   int          fails = 0;
   int          cycles = 0;
   int          answered = 0;
   bit          quiet = 0;   // no idling on either side while set
   row_type     rows [$];

   palette_blend_nearest_index i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_entry_index(req_entry_index), .req_red(req_red), .req_green(req_green),
      .req_blue(req_blue), .req_fore_index(req_fore_index),
      .req_back_index(req_back_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_nearest_index(rsp_nearest_index),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_blend_mode(csr_blend_mode)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int screen_inv(int x, int y);
      return (((x ^ 255) * (y ^ 255)) / 255) ^ 255;
   endfunction

   // one channel of a blend; half mode flips the rounding toggle first
   function int blend_channel(int f, int b);
      int v;
      case (cur_mode)
         palm_pkg::MODE_SCREEN:  return (f * (255 - b)) / 255 + b;
         palm_pkg::MODE_OVERLAY:
            return b < 128 ? (2 * b * f) / 255 : screen_inv(2 * (b - 128), f);
         palm_pkg::MODE_HARD:
            return f < 128 ? (2 * f * b) / 255 : screen_inv(2 * (f - 128), b);
         palm_pkg::MODE_DODGE: begin
            v = (b * 256) / (256 - f);
            return v > 255 ? 255 : v;
         end
         palm_pkg::MODE_HALF: begin
            toggle_bit = ~toggle_bit;
            return (f + b + int'(toggle_bit)) / 2;
         end
         default:      return (f * b) / 255;
      endcase
   endfunction

   function automatic logic [7:0] nearest_entry(int r, int g, int b);
      int best, d, idx;
      logic [23:0] c;
      best = 1000000;
      idx = 0;
      for (int i = 0; i < palm_pkg::PALETTE_ENTRIES; i++) begin
         c = shade[i];
         d = (r > c[23:16] ? r - c[23:16] : c[23:16] - r)
           + (g > c[15:8] ? g - c[15:8] : c[15:8] - g)
           + (b > c[7:0] ? b - c[7:0] : c[7:0] - b);
         if (d < best) begin
            best = d;
            idx = i;
         end
      end
      return 8'(idx);
   endfunction

   // updates the local state for one accepted command; returns 1 with the answer
   function bit predict_nearest(row_type it, output logic [7:0] idx);
      logic [23:0] fc, bc;
      int r, g, b;
      idx = '0;
      case (it.cmd)
         palm_pkg::CMD_WRITE: begin
            shade[it.ei] = {it.r, it.g, it.b};
            return 0;
         end
         palm_pkg::CMD_BLEND: begin
            fc = shade[it.fi];
            bc = shade[it.bi];
            r = blend_channel(fc[23:16], bc[23:16]);
            g = blend_channel(fc[15:8], bc[15:8]);
            b = blend_channel(fc[7:0], bc[7:0]);
            idx = nearest_entry(r, g, b);
            return 1;
         end
         palm_pkg::CMD_FIND: begin
            idx = nearest_entry(it.r, it.g, it.b);
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   task automatic wait_idle();
      while (nearest_q.size() != 0) @(posedge clock);
      // a trailing palette write may still be in the back end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_mode(logic [2:0] m);
      req_valid <= 0;
      wait_idle();
      csr_valid <= 1;
      csr_blend_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      cur_mode = m;
   endtask

   task automatic send_item(row_type it);
      int gap;
      logic [7:0] idx;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= it.cmd;
      req_entry_index <= it.ei;
      req_red <= it.r;
      req_green <= it.g;
      req_blue <= it.b;
      req_fore_index <= it.fi;
      req_back_index <= it.bi;
      do @(posedge clock); while (!req_ready);
      if (predict_nearest(it, idx))
         nearest_q.push_back(it.known ? it.want : idx);
   endtask

   // result side: random stall before each transfer
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 11);
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         answered <= answered + 1;
         if (nearest_q.size() == 0) begin
            $error("nearest_index: unexpected transfer, actual %0d", rsp_nearest_index);
            fails++;
         end else begin
            if (rsp_nearest_index !== nearest_q[0]) begin
               $error("nearest_index: expected %0d actual %0d", nearest_q[0],
                      rsp_nearest_index);
               fails++;
            end
            void'(nearest_q.pop_front());
         end
      end
   end

   function automatic row_type mk(logic [2:0] m, logic [1:0] c, int ei, int r, int g, int b,
                                  int fi, int bi, bit known = 0, int want = 0);
      row_type t;
      t.mode = m; t.cmd = c; t.ei = 8'(ei); t.r = 8'(r); t.g = 8'(g); t.b = 8'(b);
      t.fi = 8'(fi); t.bi = 8'(bi); t.known = known; t.want = 8'(want);
      return t;
   endfunction

   initial begin
      row_type it;
      int pick, phase_len, mode_pick;
      logic [23:0] c;
      toggle_bit = 0;
      cur_mode = palm_pkg::MODE_MULTIPLY;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill every entry first: entry i holds (i, 255-i, i), all distinct
      for (int i = 0; i < palm_pkg::PALETTE_ENTRIES; i++)
         send_item(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_WRITE, i, i, 255 - i, i, 0, 0));

      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_FIND, 0, 0, 255, 0, 0, 0, 1, 0));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_FIND, 0, 255, 0, 255, 0, 0, 1,
                        255));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_FIND, 0, 0, 0, 0, 0, 0, 1, 0));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_FIND, 0, 255, 255, 255, 0, 0, 1,
                        255));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 255, 255, 1,
                        255));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 0, 0, 1, 0));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, CMD_NONE, 255, 255, 255, 255, 255, 255));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_WRITE, 0, 0, 255, 0, 0, 0));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_WRITE, 255, 255, 0, 255, 0, 0));
      // duplicate color: the lower index must win the tie
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_WRITE, 10, 5, 250, 5, 0, 0));
      rows.push_back(mk(palm_pkg::MODE_MULTIPLY, palm_pkg::CMD_FIND, 0, 5, 250, 5, 0, 0, 1, 5));
      rows.push_back(mk(palm_pkg::MODE_SCREEN, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 40, 200));
      rows.push_back(mk(palm_pkg::MODE_OVERLAY, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 30, 100));
      rows.push_back(mk(palm_pkg::MODE_OVERLAY, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 200, 150));
      rows.push_back(mk(palm_pkg::MODE_HARD, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 100, 60));
      rows.push_back(mk(palm_pkg::MODE_HARD, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 220, 17));
      rows.push_back(mk(palm_pkg::MODE_DODGE, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 255, 3));
      rows.push_back(mk(palm_pkg::MODE_DODGE, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 0, 128));
      rows.push_back(mk(palm_pkg::MODE_HALF, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 1, 2));
      rows.push_back(mk(palm_pkg::MODE_HALF, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 7, 250));
      rows.push_back(mk(MODE_SPARE6, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 90, 180));
      rows.push_back(mk(MODE_SPARE7, palm_pkg::CMD_BLEND, 0, 0, 0, 0, 255, 0));
      foreach (rows[k]) begin
         if (rows[k].mode != cur_mode) write_mode(rows[k].mode);
         send_item(rows[k]);
      end

      // random phases, each under its own blend mode
      pick = 0;
      mode_pick = 0;
      while (pick < RANDOM_ITEMS) begin
         write_mode(mode_pick < 8 ? 3'(mode_pick) : 3'($urandom_range(0, 7)));
         mode_pick++;
         quiet = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 90);
         for (int k = 0; k < phase_len && pick < RANDOM_ITEMS; k++) begin
            it = mk(cur_mode, palm_pkg::CMD_WRITE, $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5: it.cmd = palm_pkg::CMD_WRITE;
               6: begin
                  // copy another entry to create ties
                  it.cmd = palm_pkg::CMD_WRITE;
                  c = shade[$urandom_range(0, 255)];
                  {it.r, it.g, it.b} = c;
               end
               7, 8, 9, 10, 11, 12: it.cmd = palm_pkg::CMD_BLEND;
               13, 14, 15: it.cmd = palm_pkg::CMD_FIND;
               16, 17: begin
                  it.cmd = palm_pkg::CMD_FIND;
                  c = shade[it.fi];
                  {it.r, it.g, it.b} = c;
               end
               default: it.cmd = CMD_NONE;
            endcase
            send_item(it);
            if (it.cmd != CMD_NONE) pick++;
         end
         quiet = 0;
      end
      req_valid <= 0;

      wait_idle();
      repeat (300) @(posedge clock);
      if (nearest_q.size() != 0) begin
         $error("nearest_index: %0d results never arrived", nearest_q.size());
         fails++;
      end
      $display("covered: palette fill, %0d directed rows, %0d random commands", rows.size(),
               pick);
      $display("blend modes 0..7 over %0d phases, %0d results compared", mode_pick, answered);
      if (fails == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ palette_blend_nearest_index.f @@
hdl/palm_pkg.sv
hdl/palm_fifo.sv
hdl/palm_back.sv
hdl/palette_blend_nearest_index.sv
bench/tb_palette_blend_nearest_index.sv
